>>> hw/rtl/ctok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ctok_pkg;

  localparam logic [7:0] CH_BLANK     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;

  localparam logic [1:0] WARN_NONE     = 2'd0;
  localparam logic [1:0] WARN_QUOTE    = 2'd1;
  localparam logic [1:0] WARN_ESCAPE   = 2'd2;

  // One parsed request for the back end; esc_pair puts a backslash result
  // ahead of the main one.
  typedef struct packed {
    logic       esc_pair;
    logic       has_byte;
    logic [7:0] data;
    logic       token_done;
    logic       line_done;
    logic [1:0] warning;
  } cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/ctok_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ctok_front
  import ctok_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] char_byte,
  input  wire logic       end_of_line,
  output logic            cmd_valid,
  output cmd_t            cmd
);

  localparam logic [2:0] ST_OUTSIDE = 3'd0;
  localparam logic [2:0] ST_WITHIN  = 3'd1;
  localparam logic [2:0] ST_ESCAPE  = 3'd2;
  localparam logic [2:0] ST_SQUOTE  = 3'd3;
  localparam logic [2:0] ST_DQUOTE  = 3'd4;
  localparam logic [2:0] ST_DESCAPE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       nonempty;
  logic       nonempty_next;
  logic       is_blank;
  logic       is_special;

  assign is_blank   = (char_byte == CH_BLANK) || (char_byte == CH_NEWLINE);
  assign is_special = (char_byte == CH_BACKSLASH) || (char_byte == CH_SQUOTE) ||
                      (char_byte == CH_DQUOTE);

  always_comb begin
    state_next         = state;
    nonempty_next      = nonempty;
    cmd_valid          = 1'b0;
    cmd.esc_pair       = 1'b0;
    cmd.has_byte       = 1'b0;
    cmd.data           = 8'd0;
    cmd.token_done     = 1'b0;
    cmd.line_done      = 1'b0;
    cmd.warning        = WARN_NONE;
    if (end_of_line) begin
      cmd_valid     = 1'b1;
      cmd.line_done = 1'b1;
      state_next    = ST_OUTSIDE;
      nonempty_next = 1'b0;
      unique case (state) inside
        ST_WITHIN: cmd.token_done = nonempty;
        ST_SQUOTE, ST_DQUOTE: begin
          cmd.token_done = 1'b1;
          cmd.warning    = WARN_QUOTE;
        end
        ST_ESCAPE, ST_DESCAPE: begin
          cmd.token_done = 1'b1;
          cmd.warning    = WARN_ESCAPE;
        end
        default: ;
      endcase
    end else begin
      unique case (state)
        ST_ESCAPE: begin
          cmd_valid     = 1'b1;
          cmd.esc_pair  = !(is_blank || is_special);
          cmd.has_byte  = 1'b1;
          cmd.data      = char_byte;
          nonempty_next = 1'b1;
          state_next    = ST_WITHIN;
        end
        ST_SQUOTE: begin
          if (char_byte == CH_SQUOTE) begin
            state_next = ST_WITHIN;
          end else begin
            cmd_valid     = 1'b1;
            cmd.has_byte  = 1'b1;
            cmd.data      = char_byte;
            nonempty_next = 1'b1;
          end
        end
        ST_DQUOTE: begin
          if (char_byte == CH_DQUOTE) begin
            state_next = ST_WITHIN;
          end else if (char_byte == CH_BACKSLASH) begin
            state_next = ST_DESCAPE;
          end else begin
            cmd_valid     = 1'b1;
            cmd.has_byte  = 1'b1;
            cmd.data      = char_byte;
            nonempty_next = 1'b1;
          end
        end
        ST_DESCAPE: begin
          cmd_valid     = 1'b1;
          cmd.esc_pair  = !((char_byte == CH_BACKSLASH) || (char_byte == CH_DQUOTE));
          cmd.has_byte  = 1'b1;
          cmd.data      = char_byte;
          nonempty_next = 1'b1;
          state_next    = ST_DQUOTE;
        end
        default: begin
          // outside (and the unused codes) and within share this arm
          if (state != ST_WITHIN && is_blank) begin
            state_next = ST_OUTSIDE;
          end else if (char_byte == CH_BACKSLASH) begin
            state_next = ST_ESCAPE;
          end else if (char_byte == CH_SQUOTE) begin
            state_next = ST_SQUOTE;
          end else if (char_byte == CH_DQUOTE) begin
            state_next = ST_DQUOTE;
          end else if (is_blank) begin
            cmd_valid      = 1'b1;
            cmd.token_done = 1'b1;
            nonempty_next  = 1'b0;
            state_next     = ST_OUTSIDE;
          end else begin
            cmd_valid     = 1'b1;
            cmd.has_byte  = 1'b1;
            cmd.data      = char_byte;
            nonempty_next = 1'b1;
            state_next    = ST_WITHIN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_OUTSIDE;
      nonempty <= 1'b0;
    end else if (accept) begin
      state    <= state_next;
      nonempty <= nonempty_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ctok_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module ctok_queue
  import ctok_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output logic      rd_valid,
  output cmd_t      rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full     = (count == DEPTH_C);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ctok_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ctok_back
  import ctok_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire cmd_t       q_data,
  output logic            q_pop,
  output logic            empty,
  input  wire logic       pop,
  output logic            has_byte,
  output logic [7:0]      out_byte,
  output logic            token_done,
  output logic            line_done,
  output logic [1:0]      warning,
  output logic            last
);

  cmd_t cur;
  logic valid;
  logic phase;
  logic first;
  logic taken;
  logic finishing;

  // first half of an escape pair: the kept backslash
  assign first     = cur.esc_pair && !phase;
  assign taken     = pop && valid;
  assign finishing = taken && !first;
  assign q_pop     = q_valid && (!valid || finishing);
  assign empty     = !valid;

  assign has_byte   = first ? 1'b1 : cur.has_byte;
  assign out_byte   = first ? CH_BACKSLASH : cur.data;
  assign token_done = first ? 1'b0 : cur.token_done;
  assign line_done  = first ? 1'b0 : cur.line_done;
  assign warning    = first ? WARN_NONE : cur.warning;
  assign last       = !first;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (q_pop) begin
        valid <= 1'b1;
        phase <= 1'b0;
      end else if (finishing) begin
        valid <= 1'b0;
        phase <= 1'b0;
      end else if (taken) begin
        phase <= 1'b1;
      end
    end
  end

  a_warn_on_line_end: assert property (@(posedge clk) disable iff (rst)
    (valid && warning != WARN_NONE) |-> line_done)
    else $error("warning raised on a result that does not end a line");

  a_pair_second_half: assert property (@(posedge clk) disable iff (rst)
    (taken && first) |=> (valid && !first && last))
    else $error("escape pair lost its second result");

  a_no_byte_on_end: assert property (@(posedge clk) disable iff (rst)
    (valid && (token_done || line_done)) |-> !has_byte)
    else $error("argument byte on an end-of-argument result");

endmodule
`default_nettype wire

>>> hw/rtl/command_line_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// Shell-style argument splitter. Push one command-line byte per cycle (or an
// end_of_line item); results come out as a queue with pop/empty. Items are
// taken every cycle while full is low; a result passes through the request
// queue and the result register before it appears. Each item gives at most
// one result, except a backslash before a byte it cannot escape, which gives
// two (backslash, then the byte) and so holds the result side for two pops.
// The front parser runs ahead of the result side through a QUEUE_DEPTH-entry
// request queue; full rises only when that queue is full, i.e. when the
// consumer stalls or escape pairs arrive faster than one result per cycle can
// drain them. Without stalls or escape pairs: one item, one result per cycle.
module command_line_tokenizer
  import ctok_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] char_byte,
  input  wire logic       end_of_line,
  output logic            empty,
  input  wire logic       pop,
  output logic            has_byte,
  output logic [7:0]      out_byte,
  output logic            token_done,
  output logic            line_done,
  output logic [1:0]      warning,
  output logic            last
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic q_valid;
  cmd_t q_data;
  logic q_pop;

  assign accept = push && !full;

  ctok_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .char_byte  (char_byte),
    .end_of_line(end_of_line),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  ctok_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && cmd_valid),
    .wr_data (cmd),
    .full    (full),
    .rd_en   (q_pop),
    .rd_valid(q_valid),
    .rd_data (q_data)
  );

  ctok_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .has_byte  (has_byte),
    .out_byte  (out_byte),
    .token_done(token_done),
    .line_done (line_done),
    .warning   (warning),
    .last      (last)
  );

endmodule
`default_nettype wire
